@@ hdl/hash_table_linear_probing_defines.svh @@
// ----------------------------------------------------------------------------
// hash table assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_LINEAR_PROBING_DEFINES_SVH
`define HASH_TABLE_LINEAR_PROBING_DEFINES_SVH

// same-cycle implication
`define HTLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTLP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/htlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_pkg
// types, codes and sizes shared by the linear probing hash table
// ----------------------------------------------------------------------------
package htlp_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int BYTE_W     = 8;
    localparam int HASH_STEPS = KEY_W / BYTE_W;
    localparam int HCNT_W     = $clog2(HASH_STEPS + 1);

    localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(NUM_SLOTS - 1);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic                    op;
        logic        [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             [1:0] status;
        logic signed [VAL_W-1:0] found_value;
        logic [SLOT_OUT_W-1:0]  slot;
    } t_rsp;

    // probe token travelling along the ring of cells
    typedef struct packed {
        logic              active;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] cnt;
    } t_tok;

    // per-cell completion report, all zero unless done
    typedef struct packed {
        logic              done;
        logic [1:0]        status;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
    } t_cell_rsp;

    // keep the low bits of a slot number for the result field
    function automatic logic [SLOT_OUT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_OUT_W-1:0] wide;
        wide = {{SLOT_OUT_W{1'b0}}, s};
        return wide[SLOT_OUT_W-1:0];
    endfunction

endpackage

@@ hdl/htlp_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_hash
// home slot unit: key mod table size, one key byte per cycle
// ----------------------------------------------------------------------------
module htlp_hash
    import htlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_home
);

    localparam int RW = SLOT_W + BYTE_W;

    logic              r_busy;
    logic              r_done;
    logic [HCNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_sh;
    logic [SLOT_W-1:0] r_rem;
    logic [SLOT_W-1:0] n_rem;

    // fold next byte into the remainder, restoring reduction per bit weight
    always_comb begin
        logic [RW-1:0] v;
        v = {r_rem, r_sh[KEY_W-1 -: BYTE_W]};
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (v >= (RW'(NUM_SLOTS) << k)) begin
                v = v - (RW'(NUM_SLOTS) << k);
            end
        end
        n_rem = v[SLOT_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == HCNT_W'(HASH_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << BYTE_W;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

@@ hdl/htlp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_cell
// one table slot plus one token stage of the probe ring
// ----------------------------------------------------------------------------
module htlp_cell
    import htlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  logic              i_inj,
    input  logic [SLOT_W-1:0] i_inj_slot,
    input  t_tok              i_inj_tok,
    input  t_tok              i_prev_tok,
    input  logic              i_hold,
    output t_tok              o_next_tok,
    output t_cell_rsp         o_rsp,
    output logic              o_active
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    t_tok             r_tok;
    t_tok             n_tok;

    logic      w_done;
    logic      w_pass;
    logic      w_write;
    t_cell_rsp w_rsp;

    // examine this slot for the token held here
    always_comb begin
        w_done = 1'b0;
        w_pass = 1'b0;
        w_rsp  = '0;
        if (r_tok.active) begin
            if (r_tok.op == OP_INSERT) begin
                priority if (!r_valid) begin
                    w_done     = 1'b1;
                    w_rsp.status = ST_INSERTED;
                    w_rsp.slot = i_idx;
                end else if (r_tok.cnt == LAST_CNT) begin
                    w_done       = 1'b1;
                    w_rsp.status = ST_FULL;
                end else begin
                    w_pass = 1'b1;
                end
            end else begin
                priority if (!r_valid) begin
                    w_done       = 1'b1;
                    w_rsp.status = ST_NOT_FOUND;
                end else if (r_key == r_tok.key) begin
                    w_done       = 1'b1;
                    w_rsp.status = ST_FOUND;
                    w_rsp.value  = r_value;
                    w_rsp.slot   = i_idx;
                end else if (r_tok.cnt == LAST_CNT) begin
                    w_done       = 1'b1;
                    w_rsp.status = ST_NOT_FOUND;
                end else begin
                    w_pass = 1'b1;
                end
            end
        end
        w_rsp.done = w_done;
    end

    assign w_write = w_done && !i_hold && (r_tok.op == OP_INSERT) && !r_valid;

    // hand the token on with one more probe counted
    always_comb begin
        o_next_tok = '0;
        if (w_pass) begin
            o_next_tok     = r_tok;
            o_next_tok.cnt = r_tok.cnt + 1'b1;
        end
    end

    // token arriving here: new request, stalled result, or neighbor
    always_comb begin
        priority if (i_inj && (i_inj_slot == i_idx)) begin
            n_tok = i_inj_tok;
        end else if (w_done && i_hold) begin
            n_tok = r_tok;
        end else begin
            n_tok = i_prev_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_key   <= r_tok.key;
            r_value <= r_tok.value;
        end
    end

    assign o_rsp    = w_rsp;
    assign o_active = r_tok.active;

endmodule

@@ hdl/hash_table_linear_probing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_linear_probing
// open addressing key/value table with linear probing over a ring of cells
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_ready carries t_req (op, key, value);
//   op insert stores key and value in the first empty slot from the home
//   slot (key mod NUM_SLOTS), op search returns the first matching entry.
//   output channel o_out_valid / i_out_ready carries t_rsp (status,
//   found_value, slot), exactly one result transaction per request.
// operation and throughput:
//   the home slot is reduced one key byte per cycle, then the request enters
//   the ring as a probe token at its home cell; the token moves one cell per
//   cycle until a cell finishes the probe and the result is registered.
//   one request is in flight at a time, so a new request is taken only after
//   the result of the last is registered; the hash and probe walk set the rate.
// reset:
//   all slots read as empty after reset; no pending request or result.
// stall:
//   a new request is taken while an earlier result waits in the output
//   register; a finished probe holds in its cell until that register frees.
// ----------------------------------------------------------------------------
`include "hash_table_linear_probing_defines.svh"

module hash_table_linear_probing
    import htlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_req       r_req;
    logic       r_out_valid;
    t_rsp       r_out_data;

    logic              w_in_acc;
    logic              w_hold;
    logic              w_inject;
    logic              w_hash_done;
    logic [SLOT_W-1:0] w_home;
    t_tok              w_inj_tok;
    t_cell_rsp         w_rsp;
    logic              w_load;

    t_tok             w_tok  [NUM_SLOTS];
    t_cell_rsp        w_crsp [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_act;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_hold   = r_out_valid && !i_out_ready;
    assign w_inject = (r_state == S_HASH) && w_hash_done;

    // home slot
    htlp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_key   (i_in_data.key),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    // token entering the ring
    always_comb begin
        w_inj_tok        = '0;
        w_inj_tok.active = 1'b1;
        w_inj_tok.op     = r_req.op;
        w_inj_tok.key    = r_req.key;
        w_inj_tok.value  = r_req.value;
    end

    // ring of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        htlp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (SLOT_W'(g)),
            .i_inj      (w_inject),
            .i_inj_slot (w_home),
            .i_inj_tok  (w_inj_tok),
            .i_prev_tok (w_tok[(g + NUM_SLOTS - 1) % NUM_SLOTS]),
            .i_hold     (w_hold),
            .o_next_tok (w_tok[g]),
            .o_rsp      (w_crsp[g]),
            .o_active   (w_act[g])
        );
    end

    // merge cell reports, at most one is nonzero
    always_comb begin
        w_rsp = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_rsp = t_cell_rsp'(w_rsp | w_crsp[i]);
        end
    end

    assign w_load = w_rsp.done && !w_hold;

    // sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_data;
        end
        if (w_load) begin
            r_out_data.status      <= w_rsp.status;
            r_out_data.found_value <= w_rsp.value;
            r_out_data.slot        <= slot_to_out(w_rsp.slot);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `HTLP_ASSERT_IMP(a_one_token, 1'b1, $onehot0(w_act), "more than one probe token in ring")
    `HTLP_ASSERT_IMP(a_probe_token, r_state == S_PROBE, $countones(w_act) == 1, "no probe token")
    `HTLP_ASSERT_IMP(a_idle_empty, o_in_ready, w_act == '0, "token left in ring while idle")
    `HTLP_ASSERT_NXT(a_load_shows, w_load, o_out_valid, "finished probe did not reach output")

endmodule

@@ tb/tb_hash_table_linear_probing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_table_linear_probing
// checks inserts and searches of the linear probing hash table against a
// cycle-free table model kept in the bench; requests are driven in random
// bursts and results are taken with random output stalls
// ----------------------------------------------------------------------------
module tb_hash_table_linear_probing;
    import htlp_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 1340;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    // bench copy of the table contents
    bit                 tbl_valid [NUM_SLOTS];
    logic [KEY_W-1:0]   tbl_key   [NUM_SLOTS];
    logic [VAL_W-1:0]   tbl_value [NUM_SLOTS];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    logic [KEY_W-1:0] issued_keys[$];

    int  err_cnt = 0;
    bit  holding = 1'b0;
    bit  req_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  stall_pct = 0;
    int  cycle_cnt = 0;

    hash_table_linear_probing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // walk the probe sequence for one request and update the table
    task automatic probe_table(input t_req rq, output t_rsp rsp);
        int unsigned s;
        bit          stop;
        rsp  = '0;
        stop = 1'b0;
        s    = rq.key % NUM_SLOTS;
        for (int n = 0; n < NUM_SLOTS; n++) begin
            if (!stop) begin
                if (rq.op == OP_INSERT) begin
                    if (!tbl_valid[s]) begin
                        tbl_valid[s]   = 1'b1;
                        tbl_key[s]     = rq.key;
                        tbl_value[s]   = rq.value;
                        rsp.status     = ST_INSERTED;
                        rsp.slot       = SLOT_OUT_W'(s);
                        stop           = 1'b1;
                    end
                end else begin
                    if (!tbl_valid[s]) begin
                        stop = 1'b1;
                    end else if (tbl_key[s] == rq.key) begin
                        rsp.status      = ST_FOUND;
                        rsp.found_value = tbl_value[s];
                        rsp.slot        = SLOT_OUT_W'(s);
                        stop            = 1'b1;
                        s               = NUM_SLOTS;
                    end
                end
                if (!stop) s = (s + 1 >= NUM_SLOTS) ? 0 : s + 1;
            end
        end
        // no empty slot, or no match, within one full pass
        if (rq.op == OP_INSERT && !stop) begin
            rsp = '0;
            rsp.status = ST_FULL;
        end else if (rq.op == OP_SEARCH && rsp.status != ST_FOUND) begin
            rsp = '0;
            rsp.status = ST_NOT_FOUND;
        end
    endtask

    task automatic push_req(input logic op, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        t_req rq;
        rq.op    = op;
        rq.key   = key;
        rq.value = value;
        pending_reqs.push_back(rq);
        if (op == OP_INSERT) issued_keys.push_back(key);
    endtask

    // random key, mostly with a few crowded home slots to build clusters
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        logic [3:0]       homes [4];
        homes = '{4'hF, 4'h0, 4'h3, 4'h7};
        k = $urandom;
        if ($urandom_range(0, 9) < 7) k[3:0] = homes[$urandom_range(0, 3)];
        return k;
    endfunction

    // request driver, bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (req_taken) begin
                req_taken = 1'b0;
                holding   = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    i_in_data <= pending_reqs.pop_front();
                    holding = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
            i_in_valid <= holding;
        end
    end

    // result receiver, stall rate is redrawn periodically
    always @(negedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 256 == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    stall_pct = 0;
                end
                1: begin
                    stall_pct = 25;
                end
                default: begin
                    stall_pct = 70;
                end
            endcase
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
            i_out_ready <= (stall_left == 0);
        end
    end

    // monitor: check results, then predict for the accepted request
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        t_rsp pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected result transaction status=%0d value=%h slot=%0d",
                                 o_out_data.status, o_out_data.found_value, o_out_data.slot);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_out_data.status !== exp_rsp.status ||
                        o_out_data.found_value !== exp_rsp.found_value ||
                        o_out_data.slot !== exp_rsp.slot) begin
                        err_cnt++;
                        // status / value / slot
                        if (err_cnt <= MAX_REPORTS)
                            $display("mismatch at %0t: expected %0d/%h/%0d, actual %0d/%h/%0d",
                                     $realtime, exp_rsp.status, exp_rsp.found_value,
                                     exp_rsp.slot, o_out_data.status,
                                     o_out_data.found_value, o_out_data.slot);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                probe_table(i_in_data, pred);
                expected_rsps.push_back(pred);
                req_taken = 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [KEY_W-1:0] k;
        // directed: empty table, wrap-around, duplicates, cluster walks
        push_req(OP_SEARCH, 32'h0000_0005, 32'h0000_0000);
        push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_req(OP_INSERT, 32'h0000_000F, 32'h8000_0000);
        push_req(OP_SEARCH, 32'h0000_000F, 32'hFFFF_FFFF);
        push_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(OP_SEARCH, 32'h0000_001F, 32'h0000_0000);
        push_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_req(OP_SEARCH, 32'h0000_0000, 32'h1234_5678);
        push_req(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        // random: inserts fill the table slowly, so searches see every load
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                if (issued_keys.size() > 0 && $urandom_range(0, 3) == 0)
                    k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                else
                    k = make_key();
                push_req(OP_INSERT, k, $urandom);
            end else begin
                if (issued_keys.size() > 0 && $urandom_range(0, 99) < 55)
                    k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                else
                    k = make_key();
                push_req(OP_SEARCH, k, $urandom);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || holding || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (NUM_SLOTS + 10) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
